// ===== rtl/core/pghc_pkg.sv =====
// Shared types and constants for the PGM header parser and crop block.
// No dependencies; every other file of the block refers to it by scoped names.

package pghc_pkg;

  // Parser phases of the header and raster walk.
  typedef enum logic [3:0] {
    PH_MAGIC_P,
    PH_MAGIC_D,
    PH_SEP_W,
    PH_NUM_W,
    PH_SEP_H,
    PH_NUM_H,
    PH_SEP_M,
    PH_NUM_M,
    PH_RASTER,
    PH_DONE
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_NOT_P5     = 3'd2,
    ST_MAXVAL     = 3'd3,
    ST_WINDOW     = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_RIGHT  = 2'd1,
    REG_WIN_TOP    = 2'd2,
    REG_WIN_BOTTOM = 2'd3
  } cfg_reg_e;

  // File type taken from the magic digit.
  typedef enum logic [1:0] {
    KIND_P4 = 2'd0,
    KIND_P5 = 2'd1,
    KIND_P6 = 2'd2
  } kind_e;

  localparam int unsigned WIN_BITS = 16;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;
  localparam int unsigned QCNT_W   = 3;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] MAXVAL   = 8'd255;

  // One queue word: an optional pixel result followed by an optional status result.
  typedef struct packed {
    logic       has_pix;
    logic [7:0] pix;
    logic       done;
    status_e    status;
  } entry_t;

endpackage

// ===== rtl/core/pghc_front.sv =====
// Front end: byte parser for the PNM header and raster counter with crop window.
// Depends on pghc_pkg; writes one queue word for every byte that yields results.

module pghc_front #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [7:0]                 file_byte_i,
  input  logic                       file_end_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [pghc_pkg::WIN_BITS-1:0] cfg_wdata_i,
  output logic                       wr_o,
  output pghc_pkg::entry_t           entry_o
);

  localparam int unsigned CW    = (DIM_BITS > pghc_pkg::WIN_BITS) ? DIM_BITS
                                                                    : pghc_pkg::WIN_BITS;
  localparam int unsigned MUL_W = DIM_BITS + 5;
  localparam logic [MUL_W-1:0] NUM_LIMIT = MUL_W'(1) << DIM_BITS;

  logic [pghc_pkg::WIN_BITS-1:0] win_left_q, win_right_q, win_top_q, win_bottom_q;

  pghc_pkg::phase_e  phase_q, phase_d;
  pghc_pkg::kind_e   kind_q, kind_d;
  logic              comment_q, comment_d;
  logic              err_q, err_d;
  logic [DIM_BITS:0] acc_q, acc_d;
  logic [DIM_BITS-1:0] width_q, width_d, height_q, height_d;
  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;

  logic              is_digit, is_sep;
  logic [DIM_BITS:0] acc_first, acc_next;
  logic [MUL_W-1:0]  acc_mul;
  logic              window_bad, in_window, win_last;
  logic [DIM_BITS:0] col_inc, row_inc;
  logic              col_last, row_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= '0;
      win_right_q  <= '0;
      win_top_q    <= '0;
      win_bottom_q <= '0;
    end else if (cfg_we_i) begin
      case (pghc_pkg::cfg_reg_e'(cfg_idx_i))
        pghc_pkg::REG_WIN_LEFT:   win_left_q   <= cfg_wdata_i;
        pghc_pkg::REG_WIN_RIGHT:  win_right_q  <= cfg_wdata_i;
        pghc_pkg::REG_WIN_TOP:    win_top_q    <= cfg_wdata_i;
        pghc_pkg::REG_WIN_BOTTOM: win_bottom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  function automatic pghc_pkg::status_e hdr_check(pghc_pkg::kind_e kind,
                                                  logic [DIM_BITS:0] maxv,
                                                  logic wbad);
    pghc_pkg::status_e st;
    if (kind != pghc_pkg::KIND_P5) st = pghc_pkg::ST_NOT_P5;
    else if (maxv != (DIM_BITS+1)'(pghc_pkg::MAXVAL)) st = pghc_pkg::ST_MAXVAL;
    else if (wbad) st = pghc_pkg::ST_WINDOW;
    else st = pghc_pkg::ST_PIXEL;
    return st;
  endfunction

  assign is_digit = (file_byte_i >= pghc_pkg::CH_0) && (file_byte_i <= pghc_pkg::CH_9);
  assign is_sep   = (file_byte_i == pghc_pkg::CH_SPACE) || (file_byte_i == pghc_pkg::CH_TAB) ||
                    (file_byte_i == pghc_pkg::CH_LF);

  // Decimal accumulate, saturating at 2^DIM_BITS so oversize numbers stay detectable.
  assign acc_first = (DIM_BITS+1)'(file_byte_i[3:0]);
  assign acc_mul   = (MUL_W'(acc_q) << 3) + (MUL_W'(acc_q) << 1) + MUL_W'(file_byte_i[3:0]);
  assign acc_next  = (acc_mul > NUM_LIMIT) ? NUM_LIMIT[DIM_BITS:0] : acc_mul[DIM_BITS:0];

  assign window_bad = (CW'(win_right_q) >= CW'(width_q)) || (win_right_q < win_left_q) ||
                      (CW'(win_bottom_q) >= CW'(height_q)) || (win_bottom_q < win_top_q);

  assign in_window = (CW'(col_q) >= CW'(win_left_q)) && (CW'(col_q) <= CW'(win_right_q)) &&
                     (CW'(row_q) >= CW'(win_top_q)) && (CW'(row_q) <= CW'(win_bottom_q));
  assign win_last  = (CW'(col_q) == CW'(win_right_q)) && (CW'(row_q) == CW'(win_bottom_q));

  assign col_inc  = {1'b0, col_q} + (DIM_BITS+1)'(1);
  assign row_inc  = {1'b0, row_q} + (DIM_BITS+1)'(1);
  assign col_last = col_inc >= {1'b0, width_q};
  assign row_last = row_inc >= {1'b0, height_q};

  always_comb begin
    pghc_pkg::status_e st;
    pghc_pkg::status_e end_st;
    pghc_pkg::status_e hc;
    pghc_pkg::phase_e  sep_target;
    logic              do_sep;
    logic              has_pix;

    phase_d    = phase_q;
    kind_d     = kind_q;
    comment_d  = comment_q;
    err_d      = err_q;
    acc_d      = acc_q;
    width_d    = width_q;
    height_d   = height_q;
    col_d      = col_q;
    row_d      = row_q;
    st         = pghc_pkg::ST_PIXEL;
    end_st     = pghc_pkg::ST_PIXEL;
    sep_target = pghc_pkg::PH_NUM_W;
    do_sep     = 1'b0;
    has_pix    = 1'b0;
    hc         = hdr_check(kind_q, acc_q, window_bad);

    if (!err_q) begin
      if (comment_q) begin
        if (file_byte_i == pghc_pkg::CH_LF) comment_d = 1'b0;
      end else begin
        case (phase_q)
          pghc_pkg::PH_MAGIC_P: begin
            if (file_byte_i == pghc_pkg::CH_HASH) comment_d = 1'b1;
            else if (file_byte_i != pghc_pkg::CH_P) st = pghc_pkg::ST_BAD_HEADER;
            else phase_d = pghc_pkg::PH_MAGIC_D;
          end
          pghc_pkg::PH_MAGIC_D: begin
            if (file_byte_i < pghc_pkg::CH_4 || file_byte_i > pghc_pkg::CH_6) begin
              st = pghc_pkg::ST_BAD_HEADER;
            end else begin
              // '4', '5' and '6' differ only in their two low bits.
              kind_d  = pghc_pkg::kind_e'(file_byte_i[1:0]);
              phase_d = pghc_pkg::PH_SEP_W;
            end
          end
          pghc_pkg::PH_SEP_W: begin
            do_sep     = 1'b1;
            sep_target = pghc_pkg::PH_NUM_W;
          end
          pghc_pkg::PH_NUM_W: begin
            if (is_digit) acc_d = acc_next;
            else if (acc_q[DIM_BITS]) st = pghc_pkg::ST_BAD_HEADER;
            else begin
              width_d    = acc_q[DIM_BITS-1:0];
              phase_d    = pghc_pkg::PH_SEP_H;
              do_sep     = 1'b1;
              sep_target = pghc_pkg::PH_NUM_H;
            end
          end
          pghc_pkg::PH_SEP_H: begin
            do_sep     = 1'b1;
            sep_target = pghc_pkg::PH_NUM_H;
          end
          pghc_pkg::PH_NUM_H: begin
            if (is_digit) acc_d = acc_next;
            else if (acc_q[DIM_BITS]) st = pghc_pkg::ST_BAD_HEADER;
            else begin
              height_d = acc_q[DIM_BITS-1:0];
              if (kind_q == pghc_pkg::KIND_P4) st = pghc_pkg::ST_NOT_P5;
              else begin
                phase_d    = pghc_pkg::PH_SEP_M;
                do_sep     = 1'b1;
                sep_target = pghc_pkg::PH_NUM_M;
              end
            end
          end
          pghc_pkg::PH_SEP_M: begin
            do_sep     = 1'b1;
            sep_target = pghc_pkg::PH_NUM_M;
          end
          pghc_pkg::PH_NUM_M: begin
            // Any non-digit ends maxval and is consumed.
            if (is_digit) acc_d = acc_next;
            else if (hc != pghc_pkg::ST_PIXEL) st = hc;
            else begin
              col_d   = '0;
              row_d   = '0;
              phase_d = pghc_pkg::PH_RASTER;
            end
          end
          pghc_pkg::PH_RASTER: begin
            has_pix = in_window;
            if (col_last) begin
              col_d = '0;
              if (row_last) phase_d = pghc_pkg::PH_DONE;
              else row_d = row_inc[DIM_BITS-1:0];
            end else begin
              col_d = col_inc[DIM_BITS-1:0];
            end
          end
          default: ;
        endcase

        if (do_sep) begin
          if (is_digit) begin
            acc_d   = acc_first;
            phase_d = sep_target;
          end else if (file_byte_i == pghc_pkg::CH_HASH) begin
            comment_d = 1'b1;
          end else if (!is_sep) begin
            st = pghc_pkg::ST_BAD_HEADER;
          end
        end
      end

      if (st != pghc_pkg::ST_PIXEL) begin
        err_d = 1'b1;
      end else if (file_end_i) begin
        // Status for a file that ends here, judged on the state this byte leaves.
        if (phase_d == pghc_pkg::PH_DONE) end_st = pghc_pkg::ST_PIXEL;
        else if (phase_d == pghc_pkg::PH_RASTER) end_st = pghc_pkg::ST_TRUNCATED;
        else if (phase_d == pghc_pkg::PH_NUM_M && !comment_d) begin
          end_st = hdr_check(kind_d, acc_d, window_bad);
          if (end_st == pghc_pkg::ST_PIXEL) end_st = pghc_pkg::ST_TRUNCATED;
        end else if (phase_d == pghc_pkg::PH_NUM_H && !comment_d &&
                     kind_d == pghc_pkg::KIND_P4 && !acc_d[DIM_BITS]) begin
          end_st = pghc_pkg::ST_NOT_P5;
        end else begin
          end_st = pghc_pkg::ST_BAD_HEADER;
        end
      end
    end

    entry_o.has_pix = has_pix;
    entry_o.pix     = file_byte_i;
    entry_o.done    = win_last;
    entry_o.status  = (st != pghc_pkg::ST_PIXEL) ? st : end_st;
    wr_o = accept_i && (has_pix || entry_o.status != pghc_pkg::ST_PIXEL);

    // The last byte of a file rearms the parser; the window registers stay.
    if (file_end_i) begin
      phase_d   = pghc_pkg::PH_MAGIC_P;
      kind_d    = pghc_pkg::KIND_P4;
      comment_d = 1'b0;
      err_d     = 1'b0;
      acc_d     = '0;
      width_d   = '0;
      height_d  = '0;
      col_d     = '0;
      row_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pghc_pkg::PH_MAGIC_P;
      kind_q    <= pghc_pkg::KIND_P4;
      comment_q <= 1'b0;
      err_q     <= 1'b0;
      acc_q     <= '0;
      width_q   <= '0;
      height_q  <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      comment_q <= comment_d;
      err_q     <= err_d;
      acc_q     <= acc_d;
      width_q   <= width_d;
      height_q  <= height_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

endmodule

// ===== rtl/core/pghc_fifo.sv =====
// Short queue of result words between the parser front end and the output back end.
// Depends on pghc_pkg for the word type and the queue depth.

module pghc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  pghc_pkg::entry_t wdata_i,
  input  logic             rd_i,
  output pghc_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  pghc_pkg::entry_t                 mem_q [pghc_pkg::QDEPTH];
  logic [pghc_pkg::QPTR_W-1:0]      wptr_q, rptr_q;
  logic [pghc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                             do_wr, do_rd;

  assign full_o  = (cnt_q == pghc_pkg::QCNT_W'(pghc_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + pghc_pkg::QCNT_W'(1);
    else if (do_rd && !do_wr) cnt_d = cnt_q - pghc_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) wptr_q <= wptr_q + pghc_pkg::QPTR_W'(1);
      if (do_rd) rptr_q <= rptr_q + pghc_pkg::QPTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// ===== rtl/core/pghc_back.sv =====
// Back end: holds the oldest queue word and presents its one or two results in turn.
// Depends on pghc_pkg for the word type and status codes.

module pghc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pghc_pkg::entry_t q_data_i,
  input  logic             q_empty_i,
  output logic             q_rd_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       pixel_value_o,
  output logic             window_done_o,
  output logic [2:0]       status_o
);

  logic             cur_valid_q;
  pghc_pkg::entry_t cur_q;
  logic             two_left, take, consume;

  // A word with both a pixel and a status shows the pixel first.
  assign two_left = cur_q.has_pix && (cur_q.status != pghc_pkg::ST_PIXEL);
  assign take     = pop_i && cur_valid_q;
  assign consume  = take && !two_left;
  assign q_rd_o   = !q_empty_i && (!cur_valid_q || consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (q_rd_o) begin
      cur_valid_q <= 1'b1;
    end else if (consume) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) cur_q <= q_data_i;
    else if (take && two_left) cur_q.has_pix <= 1'b0;
  end

  assign empty_o       = !cur_valid_q;
  assign pixel_value_o = cur_q.has_pix ? cur_q.pix : 8'd0;
  assign window_done_o = cur_q.has_pix && cur_q.done;
  assign status_o      = cur_q.has_pix ? pghc_pkg::ST_PIXEL : cur_q.status;

endmodule

// ===== rtl/core/pgm_header_parse_and_crop.sv =====
// Top level of the PNM header parser with crop window: front end, queue, back end.
// Depends on pghc_pkg, pghc_front, pghc_fifo and pghc_back.
//
//   Channel   Handshake          Payload
//   input     push_i / full_o    file_byte_i, file_end_i
//   result    empty_o / pop_i    pixel_value_o, window_done_o, status_o
//   config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// A byte is parsed in the cycle it is accepted; one byte per cycle is sustained while full_o is low.
// Its results pass through the queue and the back end's output register before they reach the result ports.
// A byte that yields a pixel and a truncation status occupies the output for two pops.
// full_o rises only when the four-word queue is full; reset empties everything.

module pgm_header_parse_and_crop #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  file_byte_i,
  input  logic        file_end_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  pixel_value_o,
  output logic        window_done_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic             accept, wr, q_rd, q_empty;
  pghc_pkg::entry_t wdata, rdata;

  assign accept = push_i && !full_o;

  pghc_front #(
    .DIM_BITS(DIM_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .file_byte_i(file_byte_i),
    .file_end_i (file_end_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wr_o       (wr),
    .entry_o    (wdata)
  );

  pghc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .wdata_i(wdata),
    .rd_i   (q_rd),
    .rdata_o(rdata),
    .full_o (full_o),
    .empty_o(q_empty)
  );

  pghc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (rdata),
    .q_empty_i    (q_empty),
    .q_rd_o       (q_rd),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .pixel_value_o(pixel_value_o),
    .window_done_o(window_done_o),
    .status_o     (status_o)
  );

endmodule

// ===== rtl/core/pghc_checker.sv =====
// Port-level checker for pgm_header_parse_and_crop, attached by the bind below.
// Depends on pghc_pkg for the status codes.

module pghc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full_o,
  input logic       pop_i,
  input logic       empty_o,
  input logic [7:0] pixel_value_o,
  input logic       window_done_o,
  input logic [2:0] status_o
);

  // Only the six defined status codes ever leave the block.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> status_o <= 3'(pghc_pkg::ST_TRUNCATED))
    else $error("status out of range");

  // An error word carries no pixel and no window-end mark.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != 3'(pghc_pkg::ST_PIXEL)) |->
      (pixel_value_o == 8'd0 && !window_done_o))
    else $error("error word carries pixel data");

  // A full queue implies the output stage already holds a word.
  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o)
    else $error("queue full while output is empty");

  // A word waiting for pop stays on the ports unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(pixel_value_o) && $stable(window_done_o) && $stable(status_o)))
    else $error("waiting word changed");

endmodule

bind pgm_header_parse_and_crop pghc_checker u_pghc_checker (.*);

// ===== dv/pghc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for pgm_header_parse_and_crop: watches the byte, result and config channels.
// It keeps its own parser and crop window, predicts result words, and compares them.
// Depends on pghc_pkg for the status, phase, kind and register codes.

module pghc_result_checker #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  file_byte_i,
  input  logic        file_end_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  pixel_value_i,
  input  logic        window_done_i,
  input  logic [2:0]  status_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          pixels_o,
  output int          errors_o
);
  import pghc_pkg::*;

  localparam int unsigned NUM_LIMIT = 32'd1 << DIM_BITS;

  typedef struct packed {
    logic [7:0] pix;
    logic       done;
    status_e    status;
  } crop_word_t;

  crop_word_t crop_results_q[$];

  logic [15:0] win_left, win_right, win_top, win_bottom;
  phase_e      phase;
  bit          in_comment;
  int unsigned acc;
  int unsigned img_w, img_h;
  int unsigned col, row;
  bit          err_latched;
  kind_e       kind;

  int fail_count;
  int pixels_seen;
  int errors_seen;
  int waiting;

  assign mismatches_o = fail_count;
  assign pending_o    = waiting;
  assign pixels_o     = pixels_seen;
  assign errors_o     = errors_seen;

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void queue_word(logic [7:0] pix, logic done, status_e st);
    crop_word_t w;
    w.pix    = pix;
    w.done   = done;
    w.status = st;
    crop_results_q.push_back(w);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  // Decimal accumulate that sticks at the limit, so oversized numbers stay detectable.
  function automatic void add_digit(logic [7:0] b);
    int unsigned v;
    v = acc * 10 + (b - CH_0);
    acc = (v > NUM_LIMIT) ? NUM_LIMIT : v;
  endfunction

  function automatic status_e header_verdict();
    if (kind != KIND_P5) return ST_NOT_P5;
    if (acc != MAXVAL) return ST_MAXVAL;
    if (win_right >= img_w || win_right < win_left ||
        win_bottom >= img_h || win_bottom < win_top) return ST_WINDOW;
    return ST_PIXEL;
  endfunction

  // Byte in a separator position: a digit opens the next number, '#' opens a comment.
  function automatic bit take_gap(logic [7:0] b, phase_e num_phase);
    if (is_digit(b)) begin
      acc = 0;
      add_digit(b);
      phase = num_phase;
      return 1'b1;
    end
    if (b == CH_HASH) begin
      in_comment = 1'b1;
      return 1'b1;
    end
    return b == CH_SPACE || b == CH_TAB || b == CH_LF;
  endfunction

  function automatic void clear_parse();
    phase       = PH_MAGIC_P;
    in_comment  = 1'b0;
    acc         = 0;
    img_w       = 0;
    img_h       = 0;
    col         = 0;
    row         = 0;
    err_latched = 1'b0;
    kind        = KIND_P4;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    status_e    st;
    logic [7:0] off;
    st = ST_PIXEL;
    if (!err_latched) begin
      if (in_comment) begin
        if (b == CH_LF) in_comment = 1'b0;
      end else begin
        case (phase)
          PH_MAGIC_P: begin
            if (b == CH_HASH) in_comment = 1'b1;
            else if (b != CH_P) st = ST_BAD_HEADER;
            else phase = PH_MAGIC_D;
          end
          PH_MAGIC_D: begin
            if (b < CH_4 || b > CH_6) st = ST_BAD_HEADER;
            else begin
              off   = b - CH_4;
              kind  = kind_e'(off[1:0]);
              phase = PH_SEP_W;
            end
          end
          PH_SEP_W: if (!take_gap(b, PH_NUM_W)) st = ST_BAD_HEADER;
          PH_NUM_W: begin
            if (is_digit(b)) add_digit(b);
            else if (acc >= NUM_LIMIT) st = ST_BAD_HEADER;
            else begin
              img_w = acc;
              phase = PH_SEP_H;
              if (!take_gap(b, PH_NUM_H)) st = ST_BAD_HEADER;
            end
          end
          PH_SEP_H: if (!take_gap(b, PH_NUM_H)) st = ST_BAD_HEADER;
          PH_NUM_H: begin
            if (is_digit(b)) add_digit(b);
            else if (acc >= NUM_LIMIT) st = ST_BAD_HEADER;
            else begin
              img_h = acc;
              if (kind == KIND_P4) st = ST_NOT_P5;
              else begin
                phase = PH_SEP_M;
                if (!take_gap(b, PH_NUM_M)) st = ST_BAD_HEADER;
              end
            end
          end
          PH_SEP_M: if (!take_gap(b, PH_NUM_M)) st = ST_BAD_HEADER;
          PH_NUM_M: begin
            if (is_digit(b)) add_digit(b);
            else begin
              st = header_verdict();
              if (st == ST_PIXEL) begin
                col   = 0;
                row   = 0;
                phase = PH_RASTER;
              end
            end
          end
          PH_RASTER: begin
            if (col >= win_left && col <= win_right && row >= win_top && row <= win_bottom)
              queue_word(b, col == win_right && row == win_bottom, ST_PIXEL);
            if (col + 1 >= img_w) begin
              col = 0;
              if (row + 1 >= img_h) phase = PH_DONE;
              else row++;
            end else begin
              col++;
            end
          end
          default: ;
        endcase
      end

      if (st != ST_PIXEL) begin
        err_latched = 1'b1;
        queue_word(8'd0, 1'b0, st);
      end else if (last) begin
        // End of file: a maxval (or a type-4 height) in progress counts as terminated.
        case (phase)
          PH_DONE:   st = ST_PIXEL;
          PH_RASTER: st = ST_TRUNCATED;
          PH_NUM_M: begin
            if (in_comment) st = ST_BAD_HEADER;
            else begin
              st = header_verdict();
              if (st == ST_PIXEL) st = ST_TRUNCATED;
            end
          end
          PH_NUM_H: begin
            if (!in_comment && kind == KIND_P4 && acc < NUM_LIMIT) st = ST_NOT_P5;
            else st = ST_BAD_HEADER;
          end
          default: st = ST_BAD_HEADER;
        endcase
        if (st != ST_PIXEL) queue_word(8'd0, 1'b0, st);
      end
    end
    if (last) clear_parse();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crop_word_t want;
    if (!rst_ni) begin
      win_left   = '0;
      win_right  = '0;
      win_top    = '0;
      win_bottom = '0;
      clear_parse();
      crop_results_q.delete();
      waiting <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WIN_LEFT:   win_left   = cfg_wdata_i;
          REG_WIN_RIGHT:  win_right  = cfg_wdata_i;
          REG_WIN_TOP:    win_top    = cfg_wdata_i;
          REG_WIN_BOTTOM: win_bottom = cfg_wdata_i;
          default: ;
        endcase
      end
      // Results popped at this edge belong to earlier bytes, so compare before predicting.
      if (pop_i && !empty_i) begin
        if (crop_results_q.size() == 0) begin
          report_mismatch($sformatf("word with nothing expected: pixel %0d done %0d status %0d",
                                    pixel_value_i, window_done_i, status_i));
        end else begin
          want = crop_results_q.pop_front();
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_i, want.status));
          if (pixel_value_i !== want.pix)
            report_mismatch($sformatf("pixel_value got %0d want %0d", pixel_value_i, want.pix));
          if (window_done_i !== want.done)
            report_mismatch($sformatf("window_done got %0d want %0d", window_done_i, want.done));
          if (want.status == ST_PIXEL) pixels_seen++;
          else errors_seen++;
        end
      end
      if (push_i && !full_i) predict_byte(file_byte_i, file_end_i);
      waiting <= crop_results_q.size();
    end
  end

endmodule

// ===== dv/pgm_header_parse_and_crop_test.sv =====
`timescale 1ns / 100ps
// Top of the pgm_header_parse_and_crop testbench: clock, reset, file stimulus and verdict.
// Depends on pghc_pkg, the block itself and pghc_result_checker.

module pgm_header_parse_and_crop_test;
  import pghc_pkg::*;

  localparam int unsigned DIM_BITS    = 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 1600;
  localparam int unsigned CALM_AFTER  = 1350;
  localparam logic [7:0]  CH_5        = CH_4 + 8'd1;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push_i      = 1'b0;
  logic [7:0]  file_byte_i = 8'd0;
  logic        file_end_i  = 1'b0;
  logic        pop_i       = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = REG_WIN_LEFT;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        full_o;
  logic        empty_o;
  logic [7:0]  pixel_value_o;
  logic        window_done_o;
  logic [2:0]  status_o;

  int mismatches, pending, pixels, errors;

  logic [7:0]  file_q[$];
  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned windows_set;
  int unsigned cycle_count;
  bit          idle_on;

  pgm_header_parse_and_crop #(.DIM_BITS(DIM_BITS)) u_top (
    .clk_i, .rst_ni, .push_i, .full_o, .file_byte_i, .file_end_i,
    .empty_o, .pop_i, .pixel_value_o, .window_done_o, .status_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  pghc_result_checker #(.DIM_BITS(DIM_BITS)) u_checker (
    .clk_i, .rst_ni, .push_i, .full_i(full_o), .file_byte_i, .file_end_i,
    .empty_i(empty_o), .pop_i, .pixel_value_i(pixel_value_o),
    .window_done_i(window_done_o), .status_i(status_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .mismatches_o(mismatches), .pending_o(pending), .pixels_o(pixels), .errors_o(errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("pgm_header_parse_and_crop verification failed");
    $finish;
  end

  // Result side: pop most cycles, with stall bursts while idling is on.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        pop_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push_i      <= 1'b1;
    file_byte_i <= b;
    file_end_i  <= last;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    int unsigned i;
    for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  // The window changes only once every expected word is out and the parser has settled.
  task automatic set_window(input logic [15:0] l, r, t, bt);
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_WIN_LEFT;
    cfg_wdata_i <= l;
    @(posedge clk_i);
    cfg_idx_i <= REG_WIN_RIGHT;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_idx_i <= REG_WIN_TOP;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_idx_i <= REG_WIN_BOTTOM;
    cfg_wdata_i <= bt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    windows_set++;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  task automatic add_number(input int unsigned v, input int unsigned zeros);
    repeat (zeros) file_q.push_back(CH_0);
    add_text($sformatf("%0d", v));
  endtask

  // Separator run: blanks and comments; a comment body may hold any byte but newline.
  task automatic add_gap(input bit need);
    int unsigned n, pick;
    logic [7:0] c;
    n = need ? $urandom_range(1, 3) : $urandom_range(0, 2);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) file_q.push_back(CH_SPACE);
      else if (pick < 5) file_q.push_back(CH_TAB);
      else if (pick < 8) file_q.push_back(CH_LF);
      else begin
        file_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          file_q.push_back(c == CH_LF ? CH_HASH : c);
        end
        file_q.push_back(CH_LF);
      end
    end
  endtask

  task automatic directed_file(input string text, input int unsigned raster_n);
    int unsigned i;
    add_text(text);
    for (i = 0; i < raster_n; i++)
      file_q.push_back(i == 0 ? 8'hFF : i == 1 ? 8'h00 : 8'($urandom_range(0, 255)));
    send_file();
  endtask

  task automatic random_file();
    int unsigned pick, w, h, maxv, full_n, n, mode, cut, header_len;
    logic [7:0]  c;
    logic [15:0] wl, wr, wt, wb;
    bit          compact;
    idle_on = (bytes_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      // Noise: random bytes, sometimes behind a valid magic.
      if ($urandom_range(0, 1) == 1) add_text("P5");
      repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom_range(0, 255)));
      send_file();
      return;
    end

    pick = $urandom_range(0, 99);
    compact = 1'b1;
    if (pick < 85) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
    end else if (pick < 93) begin
      w = $urandom_range(10, 40);
      h = $urandom_range(1, 4);
    end else if (pick < 97) begin
      compact = 1'b0;
      w = ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(1000, 65535);
      h = $urandom_range(1, 65535);
    end else begin
      compact = 1'b0;
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(65536, 999999);
      h = ($urandom_range(0, 2) == 0) ? $urandom_range(65536, 999999) : $urandom_range(0, 3);
    end

    if ($urandom_range(0, 99) < 88) maxv = 255;
    else begin
      case ($urandom_range(0, 5))
        0: maxv = 0;
        1: maxv = 254;
        2: maxv = 256;
        3: maxv = 65535;
        4: maxv = 65536;
        default: maxv = $urandom_range(100000, 9999999);
      endcase
    end

    if ($urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        wl = (w == 0) ? 16'd0 : 16'($urandom_range(0, (w > 65535 ? 65535 : w) - 1));
        wr = (w == 0) ? 16'd0 : 16'($urandom_range(wl, (w > 65535 ? 65535 : w) - 1));
        wt = (h == 0) ? 16'd0 : 16'($urandom_range(0, (h > 65535 ? 65535 : h) - 1));
        wb = (h == 0) ? 16'd0 : 16'($urandom_range(wt, (h > 65535 ? 65535 : h) - 1));
      end else if (pick < 85) begin
        wl = 16'($urandom_range(0, 65535));
        wr = 16'($urandom_range(0, 65535));
        wt = 16'($urandom_range(0, 65535));
        wb = 16'($urandom_range(0, 65535));
      end else begin
        wl = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
        wr = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'(w == 0 ? 0 : w - 1);
        wt = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
        wb = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'(h == 0 ? 0 : h - 1);
      end
      set_window(wl, wr, wt, wb);
    end

    if ($urandom_range(0, 6) == 0) add_gap(1'b1);
    file_q.push_back(CH_P);
    pick = $urandom_range(0, 99);
    file_q.push_back(pick < 92 ? CH_5 : pick < 96 ? CH_4 : CH_6);
    add_gap(1'b0);
    add_number(w, $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0);
    add_gap(1'b1);
    add_number(h, $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0);
    add_gap(1'b1);
    add_number(maxv, $urandom_range(0, 9) == 0 ? 1 : 0);
    // Exactly one byte ends maxval, and it may be any non-digit.
    pick = $urandom_range(0, 9);
    if (pick < 6) c = CH_LF;
    else if (pick < 8) c = (pick == 6) ? CH_SPACE : CH_TAB;
    else begin
      do c = 8'($urandom_range(0, 255)); while (c >= CH_0 && c <= CH_9);
    end
    file_q.push_back(c);
    header_len = file_q.size();

    full_n = compact ? w * h : 0;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      cut = $urandom_range(1, header_len - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else begin
      if (compact && mode < 84)
        n = full_n + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      else
        n = compact ? $urandom_range(0, full_n - 1) : $urandom_range(0, 30);
      repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 6)
      file_q[$urandom_range(0, (file_q.size() < header_len ? file_q.size() : header_len) - 1)]
        = 8'($urandom_range(0, 255));
    send_file();
  endtask

  initial begin
    int unsigned drain;
    bytes_sent  = 0;
    files_sent  = 0;
    windows_set = 0;
    idle_on     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window keeps only the first pixel.
    directed_file("P51 1 255\n", 1);
    set_window(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    directed_file("P5 2 1 255\n", 2);
    set_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    directed_file("P5 65535 65535 255 ", 0);
    set_window(16'd1, 16'd2, 16'd0, 16'd1);
    directed_file("# lead\nP5\t3 #c\n2\n255\n", 6);
    directed_file("P4 3 2\n", 0);
    directed_file("P6 3 2 255\n", 2);
    directed_file("P5 3 2 254\n", 0);
    directed_file("P5 65536 2 255\n", 0);
    directed_file("Q5 3 2 255\n", 2);
    directed_file("P7", 0);
    directed_file("P5 3 2 255", 0);
    // The last byte is both a window pixel and the early end of the file.
    directed_file("P5 3 2 255\n", 5);
    directed_file("P5 3 2 #x", 0);
    directed_file("P4 3 2", 0);
    directed_file("P5 3 2 255\n", 8);

    while (bytes_sent < ITEM_TARGET) random_file();

    push_i <= 1'b0;
    drain = 0;
    @(posedge clk_i);
    while (pending != 0 && drain < 4000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (pending != 0) $display("%0d expected words never arrived", pending);
    $display("run covered %0d files, %0d bytes, %0d window settings",
             files_sent, bytes_sent, windows_set);
    $display("compared %0d pixel words and %0d status words", pixels, errors);
    if (mismatches == 0 && pending == 0) begin
      $display("pgm_header_parse_and_crop verification clean");
    end else begin
      $display("pgm_header_parse_and_crop verification failed");
    end
    $finish;
  end

endmodule
